>>> hdl/iex_pkg.sv
// shared types, constants and keyword table for the include name extractor
package iex_pkg;

  localparam int MAX_NAME_DEF = 256;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int KEY_LEN = 8;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LT = 8'h3c;
  localparam logic [7:0] CH_GT = 8'h3e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       new_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       name_end;
  } out_item_t;

  typedef enum logic [3:0] {
    MODE_IDLE      = 4'b0001,
    MODE_AFTER_KEY = 4'b0010,
    MODE_IN_NAME   = 4'b0100,
    MODE_HALTED    = 4'b1000
  } scan_mode_t;

  function automatic logic [7:0] key_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0: c = CH_HASH;
      3'd1: c = 8'h69;
      3'd2: c = 8'h6e;
      3'd3: c = 8'h63;
      3'd4: c = 8'h6c;
      3'd5: c = 8'h75;
      3'd6: c = 8'h64;
      3'd7: c = 8'h65;
    endcase
    return c;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0d) || (b == 8'h08);
  endfunction

endpackage

>>> hdl/include_name_extractor_top.sv
// top level of the include name extractor: parser, result queue, config register
// usage:
//   source text enters one byte per request on in_data (text_byte, new_text);
//   a request is taken when push is high and full is low. set new_text on the
//   first byte of each text to clear the parser.
//   results leave on out_data (name_byte, name_end) while empty is low and are
//   taken when pop is high. each of the first MAX_NAME name bytes of an
//   include <...> gives one result, the closing '>' an end marker with name_byte zero.
//   cfg_data sets halt_on_text when cfg_valid is high; cfg_ready is always high.
// timing:
//   one byte per cycle while full is low; the parser handles a byte in the cycle
//   it is taken, and its result reaches out_data through the result queue.
//   results wait in a QUEUE_DEPTH entry queue; when the receiver stalls the
//   queue fills and full rises, holding off further bytes until the cycle
//   after a pop frees an entry.
// reset:
//   rst_n low clears the parser to keyword scanning, empties the queue and
//   clears halt_on_text.
module include_name_extractor_top import iex_pkg::*; #(
  parameter int MAX_NAME = MAX_NAME_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic      halt_on_text_r;
  logic      accept;
  logic      wr_en;
  out_item_t wr_item;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halt_on_text_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      halt_on_text_r <= cfg_data;
    end
  end

  iex_front #(.MAX_NAME(MAX_NAME)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .item         (in_data),
    .halt_on_text (halt_on_text_r),
    .wr_en        (wr_en),
    .wr_item      (wr_item)
  );

  iex_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_item (wr_item),
    .rd_en   (pop),
    .rd_item (out_data),
    .full    (full),
    .empty   (empty)
  );

  // results come only from accepted bytes
  a_wr_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (push && !full))
    else $error("result written without an accepted byte");

  // end marker carries a zero byte
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && wr_item.name_end) |-> (wr_item.name_byte == 8'h00))
    else $error("end marker with nonzero name byte");

  // a written result makes the queue non-empty next cycle
  a_wr_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> !empty)
    else $error("queue empty after a result was written");

  // queue is never full and empty at once
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(full && empty))
    else $error("queue full and empty together");

endmodule

>>> hdl/iex_front.sv
// front parser: keyword match, name tracking, result generation
module iex_front import iex_pkg::*; #(
  parameter int MAX_NAME = MAX_NAME_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_item_t  item,
  input  logic      halt_on_text,
  output logic      wr_en,
  output out_item_t wr_item
);

  localparam int LEN_W = $clog2(MAX_NAME + 1);

  scan_mode_t       mode_r, mode_nxt;
  logic [2:0]       km_r, km_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  scan_mode_t       mode_eff;
  logic [2:0]       km_eff;
  logic [LEN_W-1:0] len_eff;
  logic             emit;
  logic [7:0]       b;

  assign b = item.text_byte;

  always_comb begin
    // new text clears the parser before the byte is handled
    mode_eff = item.new_text ? MODE_IDLE : mode_r;
    km_eff   = item.new_text ? 3'd0 : km_r;
    len_eff  = item.new_text ? '0 : len_r;
    mode_nxt = mode_eff;
    km_nxt   = km_eff;
    len_nxt  = len_eff;
    emit     = 1'b0;
    wr_item  = '{name_byte: b, name_end: 1'b0};
    unique case (mode_eff)
      MODE_IDLE: begin
        if (b == key_char(km_eff)) begin
          if (km_eff == 3'(KEY_LEN - 1)) begin
            mode_nxt = MODE_AFTER_KEY;
            km_nxt   = 3'd0;
          end else begin
            km_nxt = km_eff + 3'd1;
          end
        end else if (halt_on_text && ((km_eff != 3'd0) || !is_blank(b))) begin
          mode_nxt = MODE_HALTED;
          km_nxt   = 3'd0;
        end else begin
          km_nxt = (b == CH_HASH) ? 3'd1 : 3'd0;
        end
      end
      MODE_AFTER_KEY: begin
        if (b == CH_LT) begin
          mode_nxt = MODE_IN_NAME;
          len_nxt  = '0;
        end
      end
      MODE_IN_NAME: begin
        if (b == CH_GT) begin
          mode_nxt = MODE_IDLE;
          km_nxt   = 3'd0;
          emit     = 1'b1;
          wr_item  = '{name_byte: 8'h00, name_end: 1'b1};
        end else if (len_eff < LEN_W'(MAX_NAME)) begin
          len_nxt = len_eff + LEN_W'(1);
          emit    = 1'b1;
        end
      end
      MODE_HALTED: begin
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase
  end

  assign wr_en = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      km_r   <= 3'd0;
      len_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      km_r   <= km_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

>>> hdl/iex_queue.sv
// result queue between the parser and the result port
module iex_queue import iex_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  out_item_t wr_item,
  input  logic      rd_en,
  output out_item_t rd_item,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule
